// ===== hw/rtl/csbh_pkg.sv =====
// ----------------------------------------------------------------------------
// csbh_pkg: shared types and constants of the CRC-64 string bucket hash
// Holds the register indexes, controller states, command bundle and the
// reflected CRC-64 byte table, which is built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package csbh_pkg;

    localparam int unsigned CRC_W      = 64;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned INDEX_W    = 31;
    localparam int unsigned CFG_ADDR_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned STEP_W     = 6;

    localparam logic [CRC_W-1:0]   CRC_INIT      = 64'hffff_ffff_ffff_ffff;
    localparam logic [CRC_W-1:0]   CRC_POLY_REFL = 64'hc96c_5795_d787_0f42;
    localparam logic [INDEX_W-1:0] TABLE_SIZE_RESET = 31'd256;
    localparam logic [STEP_W-1:0]  LAST_STEP = 6'd63;

    localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5a;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TABLE_SIZE = 8'd0,
        REG_FOLD_CASE  = 8'd1
    } csbh_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT_OUT
    } csbh_state_t;

    typedef struct packed {
        logic crc_step;
        logic crc_clear;
        logic div_load;
        logic div_step;
        logic out_load;
    } csbh_cmd_t;

    typedef logic [CRC_W-1:0] crc_table_t [256];

    function automatic crc_table_t build_crc_table();
        crc_table_t       tbl;
        logic [CRC_W-1:0] c;
        for (int i = 0; i < 256; i++) begin
            c = CRC_W'(i);
            for (int b = 0; b < 8; b++) begin
                if (c[0]) begin
                    c = (c >> 1) ^ CRC_POLY_REFL;
                end else begin
                    c = c >> 1;
                end
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage

`default_nettype wire

// ===== hw/rtl/csbh_ctrl.sv =====
// ----------------------------------------------------------------------------
// csbh_ctrl: sequencer of the CRC-64 string bucket hash
// Takes key words, starts the remainder unit on a final key, loads it for an
// empty key and hands the finished index to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csbh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_last_byte,
    input  wire logic              s_empty_key,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output csbh_pkg::csbh_cmd_t    cmd
);

    csbh_pkg::csbh_state_t             state_reg, state_next;
    logic [csbh_pkg::STEP_W-1:0]       count_reg, count_next;
    logic                              m_valid_reg, m_valid_next;

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= csbh_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            csbh_pkg::ST_IDLE: begin
                // The input is always ready here, so a valid word is taken.
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_empty_key) begin
                        // An empty key drops any partial key and yields zero.
                        cmd.crc_clear = 1'b1;
                        cmd.div_load  = 1'b1;
                        state_next    = csbh_pkg::ST_WAIT_OUT;
                    end else if (s_last_byte) begin
                        cmd.crc_clear = 1'b1;
                        cmd.div_load  = 1'b1;
                        count_next    = '0;
                        state_next    = csbh_pkg::ST_DIV;
                    end else begin
                        cmd.crc_step = 1'b1;
                    end
                end
            end
            csbh_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == csbh_pkg::LAST_STEP) begin
                    state_next = csbh_pkg::ST_WAIT_OUT;
                end
            end
            csbh_pkg::ST_WAIT_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = csbh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csbh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/csbh_dpath.sv =====
// ----------------------------------------------------------------------------
// csbh_dpath: datapath of the CRC-64 string bucket hash
// Configuration registers, table-driven CRC register, bit-serial restoring
// remainder unit and the output index register.
// ----------------------------------------------------------------------------
`default_nettype none

module csbh_dpath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire csbh_pkg::csbh_cmd_t                 cmd,
    input  wire logic [csbh_pkg::BYTE_W-1:0]         s_key_byte,
    input  wire logic                                s_empty_key,
    input  wire logic                                cfg_write,
    input  wire logic [csbh_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  wire logic [csbh_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [csbh_pkg::INDEX_W-1:0]             m_bucket_index
);

    logic [csbh_pkg::INDEX_W-1:0] table_size_reg, table_size_next;
    logic                         fold_case_reg, fold_case_next;
    logic [csbh_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [csbh_pkg::CRC_W-1:0]   dividend_reg, dividend_next;
    logic [csbh_pkg::INDEX_W-1:0] divisor_reg, divisor_next;
    logic [csbh_pkg::INDEX_W-1:0] rem_reg, rem_next;
    logic                         zero_res_reg, zero_res_next;
    logic [csbh_pkg::INDEX_W-1:0] index_reg, index_next;

    logic [csbh_pkg::BYTE_W-1:0]  byte_in;
    logic [csbh_pkg::BYTE_W-1:0]  tbl_idx;
    logic [csbh_pkg::CRC_W-1:0]   crc_upd;
    logic [csbh_pkg::CRC_W-1:0]   folded;
    logic [csbh_pkg::INDEX_W:0]   rem_shift;
    logic [csbh_pkg::INDEX_W:0]   rem_diff;

    assign m_bucket_index = index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= csbh_pkg::TABLE_SIZE_RESET;
            fold_case_reg  <= 1'b0;
            crc_reg        <= csbh_pkg::CRC_INIT;
        end else begin
            table_size_reg <= table_size_next;
            fold_case_reg  <= fold_case_next;
            crc_reg        <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        zero_res_reg <= zero_res_next;
        index_reg    <= index_next;
    end

    // Configuration writes; indexes beyond the register list are ignored.
    always_comb begin
        table_size_next = table_size_reg;
        fold_case_next  = fold_case_reg;
        if (cfg_write) begin
            if (cfg_index == csbh_pkg::REG_TABLE_SIZE) begin
                table_size_next = cfg_data[csbh_pkg::INDEX_W-1:0];
            end else if (cfg_index == csbh_pkg::REG_FOLD_CASE) begin
                fold_case_next = cfg_data[0];
            end
        end
    end

    // Byte update of the reflected CRC, one table lookup per word.
    always_comb begin
        byte_in = s_key_byte;
        if (fold_case_reg && s_key_byte >= csbh_pkg::UPPER_A
                && s_key_byte <= csbh_pkg::UPPER_Z) begin
            byte_in = s_key_byte + csbh_pkg::CASE_DELTA;
        end
        tbl_idx = crc_reg[csbh_pkg::BYTE_W-1:0] ^ byte_in;
        crc_upd = (crc_reg >> csbh_pkg::BYTE_W) ^ csbh_pkg::CRC_TABLE[tbl_idx];
        folded  = crc_upd ^ {32'h0, crc_upd[csbh_pkg::CRC_W-1:32]};
    end

    always_comb begin
        priority if (cmd.crc_clear) begin
            crc_next = csbh_pkg::CRC_INIT;
        end else if (cmd.crc_step) begin
            crc_next = crc_upd;
        end else begin
            crc_next = crc_reg;
        end
    end

    // Restoring remainder, one dividend bit per cycle, most significant first.
    // The partial remainder stays below the divisor, so it fits in 31 bits.
    always_comb begin
        rem_shift     = {rem_reg, dividend_reg[csbh_pkg::CRC_W-1]};
        rem_diff      = rem_shift - {1'b0, divisor_reg};
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        zero_res_next = zero_res_reg;
        index_next    = index_reg;

        if (cmd.div_load) begin
            dividend_next = folded;
            divisor_next  = table_size_reg;
            rem_next      = '0;
            zero_res_next = s_empty_key || (table_size_reg == '0);
        end else if (cmd.div_step) begin
            dividend_next = {dividend_reg[csbh_pkg::CRC_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, divisor_reg}) begin
                rem_next = rem_diff[csbh_pkg::INDEX_W-1:0];
            end else begin
                rem_next = rem_shift[csbh_pkg::INDEX_W-1:0];
            end
        end

        if (cmd.out_load) begin
            index_next = zero_res_reg ? '0 : rem_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/crc64_string_bucket_hash_top.sv =====
// ----------------------------------------------------------------------------
// crc64_string_bucket_hash_top: CRC-64 string key to bucket index hasher
// Hashes keys given a byte per word and reduces the folded CRC to a bucket.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready) carries one key byte per word, with
//   s_last_byte marking the final byte and s_empty_key standing for a whole
//   empty key. The result channel (m_valid/m_ready) carries one bucket index
//   per key. The configuration channel (cfg_valid/cfg_ready) writes the table
//   size (index 0) and the case-fold mode (index 1); it is always ready.
//   A byte that is not the last is taken and the next word can be taken
//   in the following cycle. A last byte starts the remainder unit, which
//   takes one dividend bit per cycle; input is held off until the index
//   has gone to the output register. An empty key gives index 0 once the
//   output register is free.
//   The result sits in an output register; further key bytes are accepted
//   while it waits. If the receiver stalls, a second finished index waits in
//   the remainder unit until the output register is free.
//   Reset clears the CRC to all ones, the table size to 256 and case folding
//   to off, and drops any result not yet taken.
// ----------------------------------------------------------------------------
`default_nettype none

module crc64_string_bucket_hash_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [csbh_pkg::BYTE_W-1:0]         s_key_byte,
    input  wire logic                                s_last_byte,
    input  wire logic                                s_empty_key,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [csbh_pkg::INDEX_W-1:0]             m_bucket_index,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [csbh_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  wire logic [csbh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    csbh_pkg::csbh_cmd_t cmd;

    assign cfg_ready = 1'b1;

    csbh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_byte (s_last_byte),
        .s_empty_key (s_empty_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    csbh_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_key_byte     (s_key_byte),
        .s_empty_key    (s_empty_key),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_bucket_index (m_bucket_index)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the CRC-64 string bucket hasher
// Streams key bytes through the input channel, keeps a shadow of the CRC
// register and the configuration, and checks every bucket index against it.
// ----------------------------------------------------------------------------
module testbench;
    import csbh_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned MAX_GAP      = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_key_byte;
    logic                  s_last_byte;
    logic                  s_empty_key;
    logic                  m_valid;
    logic                  m_ready;
    logic [INDEX_W-1:0]    m_bucket_index;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block's state and registers.
    logic [CRC_W-1:0]      crc_shadow;
    logic [INDEX_W-1:0]    shadow_table_size;
    logic                  shadow_fold_case;
    logic [INDEX_W-1:0]    expected_buckets [$];

    int unsigned           cycle_count;
    int unsigned           error_count;
    int unsigned           words_sent;
    int unsigned           result_hold;
    bit                    idling_on;

    crc64_string_bucket_hash_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .s_last_byte    (s_last_byte),
        .s_empty_key    (s_empty_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic int unsigned draw_gap();
        return idling_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic logic [CRC_W-1:0] crc64_byte(logic [CRC_W-1:0] crc,
                                                    logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    // Updates the shadow CRC for one accepted word and queues any bucket due.
    task automatic predict_key_word(input logic [BYTE_W-1:0] kb, input logic lb,
                                    input logic ek);
        logic [BYTE_W-1:0] b;
        logic [CRC_W-1:0]  folded;
        if (ek) begin
            crc_shadow = CRC_INIT;
            expected_buckets.push_back('0);
        end else begin
            b = kb;
            if (shadow_fold_case && b >= UPPER_A && b <= UPPER_Z) begin
                b = b + CASE_DELTA;
            end
            crc_shadow = crc64_byte(crc_shadow, b);
            if (lb) begin
                folded = crc_shadow ^ (crc_shadow >> 32);
                crc_shadow = CRC_INIT;
                if (shadow_table_size == '0) begin
                    expected_buckets.push_back('0);
                end else begin
                    expected_buckets.push_back(
                        INDEX_W'(folded % {{(CRC_W-INDEX_W){1'b0}}, shadow_table_size}));
                end
            end
        end
    endtask

    // Offers one word and returns at the edge where it is taken; valid stays
    // high so that a following word without a gap goes out back to back.
    task automatic send_word(input logic [BYTE_W-1:0] kb, input logic lb,
                             input logic ek);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_key_byte  <= kb;
        s_last_byte <= lb;
        s_empty_key <= ek;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_key_word(kb, lb, ek);
        words_sent++;
    endtask

    task automatic send_key(input logic [BYTE_W-1:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++) begin
            send_word(bytes[i], i == bytes.size() - 1, 1'b0);
        end
    endtask

    // Stops the input and waits until every bucket has come out and the
    // remainder unit can no longer be busy.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_buckets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input csbh_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_TABLE_SIZE) begin
            shadow_table_size = data[INDEX_W-1:0];
        end else begin
            shadow_fold_case = data[0];
        end
    endtask

    function automatic logic [BYTE_W-1:0] random_key_byte();
        case ($urandom_range(0, 3))
            0, 1:    return BYTE_W'($urandom_range(UPPER_A, UPPER_Z));
            2:       return BYTE_W'($urandom_range(8'h20, 8'h7e));
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Reset defaults: a letter, the zero byte, the all-ones byte and a three-byte key.
    task automatic test_reset_defaults();
        idling_on = 1'b1;
        send_key('{UPPER_A});
        send_key('{8'h00});
        send_key('{8'hff});
        send_key('{8'h61, 8'h62, 8'h63});
    endtask

    // Empty keys ignore the other fields and drop a partly hashed key.
    task automatic test_empty_keys();
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h62, 1'b0, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);
        send_key('{8'h61, 8'h62});
    endtask

    // Smallest, largest and zero table size; bit 31 of the data is dropped.
    task automatic test_table_size_extremes();
        write_register(REG_TABLE_SIZE, 32'd1);
        send_key('{8'h6b, 8'h65, 8'h79});
        write_register(REG_TABLE_SIZE, 32'hffff_ffff);
        send_key('{8'h6b, 8'h65, 8'h79});
        send_key('{8'h00});
        write_register(REG_TABLE_SIZE, 32'h8000_0000);
        send_key('{8'h6b, 8'h65, 8'h79});
    endtask

    // Case folding around the letter range, then a mode change mid-key.
    task automatic test_fold_case();
        write_register(REG_TABLE_SIZE, 32'd4093);
        write_register(REG_FOLD_CASE, 32'd1);
        send_key('{UPPER_A, UPPER_Z, 8'h40, 8'h5b});
        send_key('{8'h61, 8'h7a, 8'h40, 8'h5b});
        send_word(8'h51, 1'b0, 1'b0);
        write_register(REG_FOLD_CASE, 32'd0);
        send_word(8'h51, 1'b1, 1'b0);
        wait_idle();
    endtask

    // The receiver holds off while short keys keep arriving, so the output
    // register and the remainder unit fill and the input stalls.
    task automatic test_back_pressure();
        write_register(REG_TABLE_SIZE, 32'd97);
        idling_on = 1'b0;
        result_hold = 600;
        for (int k = 0; k < 30; k++) begin
            if ($urandom_range(0, 1) != 0) begin
                send_word(random_key_byte(), 1'b0, 1'b0);
            end
            send_word(random_key_byte(), 1'b1, 1'b0);
        end
        wait_idle();
    endtask

    // Mostly well-formed keys with random content, plus empty keys, keys cut
    // short by an empty key, and words with random flags.
    task automatic run_random_phase(input int unsigned n_words);
        int unsigned       start;
        int unsigned       len;
        logic [BYTE_W-1:0] bytes [$];
        start = words_sent;
        while (words_sent - start < n_words) begin
            case ($urandom_range(0, 9))
                0: send_word(BYTE_W'($urandom), 1'($urandom), 1'b1);
                1: begin
                    len = $urandom_range(1, 5);
                    repeat (len) send_word(random_key_byte(), 1'b0, 1'b0);
                    send_word(BYTE_W'($urandom), 1'($urandom), 1'b1);
                end
                2: send_word(BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                default: begin
                    len = $urandom_range(1, 10);
                    bytes.delete();
                    repeat (len) bytes.push_back(random_key_byte());
                    send_key(bytes);
                end
            endcase
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        write_register(REG_TABLE_SIZE, 32'($urandom_range(1, 1000)));
        write_register(REG_FOLD_CASE, 32'd1);
        idling_on = 1'b1;
        run_random_phase(200);
        write_register(REG_TABLE_SIZE, $urandom);
        write_register(REG_FOLD_CASE, 32'hffff_fffe);
        idling_on = 1'b0;
        run_random_phase(200);
        write_register(REG_TABLE_SIZE, 32'h7fff_ffff);
        write_register(REG_FOLD_CASE, 32'hffff_ffff);
        idling_on = 1'b1;
        run_random_phase(200);
        write_register(REG_TABLE_SIZE, 32'($urandom_range(1, 16)));
        write_register(REG_FOLD_CASE, 32'($urandom_range(0, 1)));
        run_random_phase(100);
        idling_on = 1'b0;
        run_random_phase(100);
    endtask

    // Result side: after each word taken it waits a random gap, if idling is on,
    // before taking the next, unless a long hold is in force.
    initial begin : result_ready_driver
        int unsigned countdown;
        countdown = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                countdown = draw_gap();
            end
            if (result_hold != 0) begin
                result_hold--;
                m_ready <= 1'b0;
            end else if (countdown != 0) begin
                countdown--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : bucket_checker
        logic [INDEX_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_buckets.size() == 0) begin
                $error("bucket_index: no result expected, got %0d", m_bucket_index);
                error_count++;
            end else begin
                want = expected_buckets.pop_front();
                if (m_bucket_index !== want) begin
                    $error("bucket_index: expected %0d, got %0d", want, m_bucket_index);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        error_count       = 0;
        words_sent        = 0;
        result_hold       = 0;
        idling_on         = 1'b0;
        crc_shadow        = CRC_INIT;
        shadow_table_size = TABLE_SIZE_RESET;
        shadow_fold_case  = 1'b0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_key_byte  <= '0;
        s_last_byte <= 1'b0;
        s_empty_key <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_empty_keys();
        test_table_size_extremes();
        test_fold_case();
        test_back_pressure();
        test_random_traffic();
        wait_idle();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
